// ===== hdl/dtp_pkg.sv =====
// Shared types and constants for the digit trie prefix checker.
package dtp_pkg;

    // Width of the digit field in the input word
    localparam int DIGIT_W = 4;

    // Fixed node numbers: node 0 marks an empty link, node 1 is the root
    localparam int ROOT_NODE  = 1;
    localparam int FIRST_FREE = 2;

    // Input opcodes
    localparam logic OP_DIGIT = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    // Result flags handed from the sequencer to the output stage
    typedef struct packed {
        logic table_full;
        logic list_consistent;
    } result_t;

endpackage

// ===== hdl/digit_trie_prefix_checker.sv =====
// Top level of the digit trie prefix checker: link table, sequencer, output register.
//
// Checks a list of decimal numbers for the prefix property. Input words arrive on the
// s_axis channel, one digit per word: tdata[3:0] is the digit, tlast marks the last
// digit of a number, tuser selects a digit word (0) or a clear of the table (1).
// Numbers must be sent longest first. On each last digit one word leaves on m_axis:
// tdata[0] = list still consistent, tdata[1] = node table ran full. Other words give
// no output.
// A digit word is handled in steps: the child link of the current node is read from the
// link table, then followed, or a node is allocated and the new link written back; the
// next digit needs the node this one finds, so one digit is in flight at a time.
// A last digit's result is loaded into the output register behind m_axis_tvalid.
// After reset and each clear word, s_axis_tready is low while the table is swept to
// zero one entry per cycle: MAX_NODES*RADIX entries (40960 with the defaults).
// The result sits in an output register; a stalled receiver does not block the next
// digit, only the next result, which waits inside until the register empties.
module digit_trie_prefix_checker
    import dtp_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int RADIX     = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [3:0] digit, [7:4] zero
    input  logic       s_axis_tlast,  // last_digit
    input  logic [0:0] s_axis_tuser,  // [0] opcode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [0] list_consistent, [1] table_full, [7:2] zero
);

    localparam int DEPTH  = MAX_NODES * RADIX;
    localparam int LINK_W = $clog2(MAX_NODES);
    localparam int ADDR_W = $clog2(DEPTH);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    logic              slot_free;
    logic              res_load;
    result_t           res;

    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    dtp_link_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (LINK_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dtp_seq #(
        .MAX_NODES (MAX_NODES),
        .RADIX     (RADIX),
        .LINK_W    (LINK_W),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser[0]),
        .in_digit  (s_axis_tdata[DIGIT_W-1:0]),
        .in_last   (s_axis_tlast),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: free when empty or being taken this cycle
    assign slot_free      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_res_reg.table_full, out_res_reg.list_consistent};

endmodule

// ===== hdl/dtp_link_ram.sv =====
// Child-link table: one write port and one registered read port.
module dtp_link_ram #(
    parameter int DEPTH  = 40960,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/dtp_seq.sv =====
// Sequencer: trie walk, node allocation, sticky flags and table clearing pass.
module dtp_seq
    import dtp_pkg::*;
#(
    parameter int MAX_NODES = 4096,
    parameter int RADIX     = 10,
    parameter int LINK_W    = 12,
    parameter int ADDR_W    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // input word
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [DIGIT_W-1:0] in_digit,
    input  logic               in_last,
    // result hand-off
    input  logic               slot_free,
    output logic               res_load,
    output result_t            res,
    // link table
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [LINK_W-1:0]  ram_wdata,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [LINK_W-1:0]  ram_rdata
);

    localparam int DEPTH  = MAX_NODES * RADIX;
    localparam int FREE_W = LINK_W + 1;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                step_reg, step_next;
    logic                last_reg, last_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic                created_reg, created_next;
    logic                conflict_reg, conflict_next;
    logic                full_reg, full_next;

    logic                accept;
    logic                digit_ok;
    logic [ADDR_W-1:0]   step_addr;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // address of the child link for this digit
    assign digit_ok  = ({1'b0, in_digit} < (DIGIT_W + 1)'(RADIX));
    assign step_addr = ADDR_W'(cur_reg) * ADDR_W'(RADIX) + ADDR_W'(in_digit);

    assign ram_re    = accept && (in_op == OP_DIGIT);
    assign ram_raddr = step_addr;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        step_next     = step_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        created_next  = created_reg;
        conflict_next = conflict_reg;
        full_next     = full_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = free_reg[LINK_W-1:0];
        res_load      = 1'b0;
        res.list_consistent = !conflict_reg;
        res.table_full      = full_reg;

        case (state_reg)
            // sweep the table to zero, one entry a cycle
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take a word; digits launch the link read
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_CLEAR)
                    begin
                        clr_addr_next = '0;
                        cur_next      = LINK_W'(ROOT_NODE);
                        free_next     = FREE_W'(FIRST_FREE);
                        created_next  = 1'b0;
                        conflict_next = 1'b0;
                        full_next     = 1'b0;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        addr_next  = step_addr;
                        step_next  = digit_ok && !conflict_reg && !full_reg;
                        last_next  = in_last;
                        state_next = S_EVAL;
                    end
                end
            end

            // follow or allocate, then close the number on its last digit
            S_EVAL:
            begin
                if (step_reg)
                begin
                    if (ram_rdata == '0)
                    begin
                        if (free_reg >= FREE_W'(MAX_NODES))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            cur_next     = free_reg[LINK_W-1:0];
                            free_next    = free_reg + 1'b1;
                            created_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_next = ram_rdata;
                    end
                end
                state_next = S_IDLE;
                if (last_reg)
                begin
                    if (!conflict_reg && !full_next && !created_next)
                    begin
                        conflict_next = 1'b1;
                    end
                    cur_next     = LINK_W'(ROOT_NODE);
                    created_next = 1'b0;
                    res.list_consistent = !conflict_next;
                    res.table_full      = full_next;
                    if (slot_free)
                    begin
                        res_load = 1'b1;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end

            // output slot busy: flags are sticky, so load them once it frees
            S_HOLD:
            begin
                if (slot_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= 1'b0;
            last_reg     <= 1'b0;
            cur_reg      <= LINK_W'(ROOT_NODE);
            free_reg     <= FREE_W'(FIRST_FREE);
            created_reg  <= 1'b0;
            conflict_reg <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
            last_reg     <= last_next;
            cur_reg      <= cur_next;
            free_reg     <= free_next;
            created_reg  <= created_next;
            conflict_reg <= conflict_next;
            full_reg     <= full_next;
        end
    end

    // link address needs no reset
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

endmodule

// ===== hdl/dtp_checker.sv =====
// Port-level checks for the digit trie prefix checker, bound to the top level.
module dtp_checker
    import dtp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its flags
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one word in flight: the block is busy right after it takes a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // a clear word starts the table sweep, which keeps the input not ready
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_CLEAR)
        |=> ##1 !s_axis_tready)
        else $error("input ready during table clear");

endmodule

bind digit_trie_prefix_checker dtp_checker u_dtp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the digit trie prefix checker.
module testbench
    import dtp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_NODES   = 4096;
    localparam int TB_RADIX       = 10;
    localparam int LINK_DEPTH     = TB_MAX_NODES * TB_RADIX;
    // clear sweep writes all LINK_DEPTH entries; allow it several times over
    localparam int WATCHDOG_LIMIT = 4 * LINK_DEPTH;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_PCT       = 26;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [3:0] digit, [7:4] zero
    logic       s_axis_tlast = 1'b0; // last_digit
    logic [0:0] s_axis_tuser = '0;   // [0] opcode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [0] list_consistent, [1] table_full, [7:2] zero

    // Shadow trie used to predict every result word
    logic [11:0] link_tab [LINK_DEPTH];
    logic [12:0] free_node;
    logic [11:0] cur_node;
    logic        made_node;
    logic        trie_conflict;
    logic        trie_full;
    result_t     expected_flags [$];

    // Digits of the number being sent and of the one before it
    logic [DIGIT_W-1:0] num_buf [$];
    logic [DIGIT_W-1:0] prev_num [$];

    // Flow control knobs
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Run statistics
    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int inconsistent_seen = 0;
    int full_reports = 0;
    int stall_cycles = 0;

    digit_trie_prefix_checker #(
        .MAX_NODES(TB_MAX_NODES),
        .RADIX    (TB_RADIX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Empty the shadow trie
    task automatic trie_wipe();
        for (int i = 0; i < LINK_DEPTH; i++)
            link_tab[i] = '0;
        free_node     = 13'(FIRST_FREE);
        cur_node      = 12'(ROOT_NODE);
        made_node     = 1'b0;
        trie_conflict = 1'b0;
        trie_full     = 1'b0;
    endtask

    // Apply one accepted word to the shadow trie, queue a result on a last digit
    task automatic trie_predict(input logic op, input logic [DIGIT_W-1:0] dg, input logic lst);
        int      slot;
        result_t res;
        if (op == OP_CLEAR)
        begin
            trie_wipe();
            return;
        end
        // walk or grow the path; out-of-range digits take no step
        if (!trie_conflict && !trie_full && dg < TB_RADIX && cur_node < TB_MAX_NODES)
        begin
            slot = int'(cur_node) * TB_RADIX + int'(dg);
            if (link_tab[slot] == '0)
            begin
                if (free_node >= TB_MAX_NODES)
                    trie_full = 1'b1;
                else
                begin
                    link_tab[slot] = free_node[11:0];
                    cur_node       = free_node[11:0];
                    free_node      = free_node + 1'b1;
                    made_node      = 1'b1;
                end
            end
            else
                cur_node = link_tab[slot];
        end
        if (lst)
        begin
            // a number that built nothing sits on an existing path
            if (!trie_conflict && !trie_full && !made_node)
                trie_conflict = 1'b1;
            res.list_consistent = !trie_conflict;
            res.table_full      = trie_full;
            expected_flags = {expected_flags, res};
            cur_node  = 12'(ROOT_NODE);
            made_node = 1'b0;
        end
    endtask

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input logic op, input logic [DIGIT_W-1:0] dg, input logic lst);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, dg};
        s_axis_tlast  <= lst;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        trie_predict(op, dg, lst);
        words_sent++;
    endtask

    // Send the digits in num_buf as one number
    task automatic send_number();
        for (int i = 0; i < num_buf.size(); i++)
            send_word(OP_DIGIT, num_buf[i], i == num_buf.size() - 1);
        prev_num = num_buf;
    endtask

    // Clear word; digit and last mark carry random junk
    task automatic clear_table();
        send_word(OP_CLEAR, DIGIT_W'($urandom_range(15)), 1'($urandom_range(1)));
        prev_num.delete();
    endtask

    // Sender stops until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load num_buf with len random digits in 0..hi
    task automatic fill_number(input int len, input int hi);
        num_buf.delete();
        repeat (len) num_buf = {num_buf, DIGIT_W'($urandom_range(hi))};
    endtask

    // Directed: prefixes, equal numbers, extreme and out-of-range digits, clears
    task automatic test_directed_prefix();
        num_buf = '{4'd9, 4'd0, 4'd9};
        send_number();
        num_buf = '{4'd0, 4'd0};
        send_number();
        // out-of-range digits skipped, rest is a prefix of 909
        num_buf = '{4'd10, 4'd9, 4'd0, 4'd11};
        send_number();
        // ignored after the conflict, flag stays sticky
        num_buf = '{4'd5};
        send_number();
        send_word(OP_CLEAR, 4'd15, 1'b1);
        num_buf = '{4'd12, 4'd3, 4'd15};
        send_number();
        // no valid digit at all: the empty string is a prefix
        num_buf = '{4'd13, 4'd14};
        send_number();
        send_word(OP_CLEAR, 4'd6, 1'b0);
        // duplicate number
        num_buf = '{4'd1, 4'd2, 4'd3};
        send_number();
        send_number();
        drain_results();
    endtask

    // Grow the trie until node allocation saturates, then keep going a while
    task automatic test_table_full();
        int guard;
        clear_table();
        guard = 0;
        while (!trie_full && guard < 2000)
        begin
            fill_number(10, 9);
            send_number();
            guard++;
        end
        repeat (20)
        begin
            fill_number($urandom_range(4, 1), 15);
            send_number();
        end
        drain_results();
    endtask

    // Long receiver stall while the sender keeps pushing, then a sender pause
    task automatic test_backpressure();
        clear_table();
        fill_number(3, 9);
        send_number();
        hold_reqs <= hold_reqs + 1;
        repeat (40)
        begin
            fill_number(3, 9);
            send_number();
        end
        drain_results();
        repeat (10)
        begin
            fill_number(2, 9);
            send_number();
        end
        drain_results();
    endtask

    // One list after a clear: mostly well-formed, longest first, plus noise and prefixes
    task automatic random_list(input int n_items, input int noise_pct, input int prefix_pct);
        int sent;
        int len;
        int roll;
        int cut;
        clear_table();
        sent = 0;
        len  = 10;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < noise_pct)
                fill_number($urandom_range(4, 1), 15);
            else if (roll < noise_pct + prefix_pct && prev_num.size() > 0)
            begin
                cut = $urandom_range(prev_num.size(), 1);
                num_buf.delete();
                for (int i = 0; i < cut; i++)
                    num_buf = {num_buf, prev_num[i]};
            end
            else
            begin
                if (len > 1 && $urandom_range(7) == 0)
                    len--;
                fill_number(len, 9);
            end
            send_number();
            sent += num_buf.size();
        end
        drain_results();
    endtask

    task automatic test_random_lists();
        random_list(325, 0, 0);
        // stretch with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        random_list(325, 0, 0);
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        random_list(325, 12, 0);
        random_list(325, 5, 4);
    endtask

    task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_reqs != hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_served   <= hold_reqs;
            hold_left     <= RX_HOLD_CYCLES;
        end
        else
            m_axis_tready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
    end

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (!m_axis_tdata[0])
                inconsistent_seen++;
            if (m_axis_tdata[1])
                full_reports++;
            if (expected_flags.size() == 0)
                flag_mismatch("result word with none expected", -1, int'(m_axis_tdata));
            else
            begin
                want = expected_flags.pop_front();
                if (m_axis_tdata[0] !== want.list_consistent)
                    flag_mismatch("list_consistent", int'(want.list_consistent),
                                  int'(m_axis_tdata[0]));
                if (m_axis_tdata[1] !== want.table_full)
                    flag_mismatch("table_full", int'(want.table_full), int'(m_axis_tdata[1]));
                if (m_axis_tdata[7:2] !== 6'b0)
                    flag_mismatch("tdata padding", 0, int'(m_axis_tdata[7:2]));
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        trie_wipe();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_prefix();
        test_table_full();
        test_backpressure();
        test_random_lists();

        drain_results();
        if (expected_flags.size() != 0)
        begin
            mismatches += expected_flags.size();
            $display("%0d expected result words never arrived", expected_flags.size());
        end

        $display("Covered %0d input words and %0d result words (%0d inconsistent, %0d full)",
                 words_sent, results_seen, inconsistent_seen, full_reports);
        $display("Included prefix and duplicate numbers, bad digits, table saturation, stalls");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
